// ----- rtl/core/skp_pkg.sv -----
// Shared types and constants for the skyline strip packer.
// No dependencies.
package skp_pkg;

  localparam int PieceWidthW  = 7;
  localparam int PieceHeightW = 16;
  localparam int StripWidthW  = 7;
  localparam int CoordW       = 6;
  localparam int OutHeightW   = 16;

  localparam logic [StripWidthW-1:0] StripWidthReset = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MIN,
    ST_COMMIT,
    ST_MAX,
    ST_OUT
  } skp_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic accept;      // latch request, load window and start flags
    logic scan;        // one window step, all starts in parallel
    logic min_load;    // load candidates for the lowest-start search
    logic reduce_min;  // one tournament level, lowest height wins
    logic commit;      // raise covered columns, load candidates for length
    logic reduce_max;  // one tournament level, highest height wins
    logic out_load;    // move result into the output register
  } skp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic reduce_last;
    logic out_free;
  } skp_sts_t;

endpackage

// ----- rtl/core/skp_ctrl.sv -----
// Sequencing state machine of the skyline strip packer.
// Depends on skp_pkg.
module skp_ctrl import skp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  skp_sts_t sts_i,
  output skp_cmd_t cmd_o
);

  skp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.min_load = 1'b1;
          state_d        = ST_MIN;
        end
      end
      ST_MIN: begin
        cmd_o.reduce_min = 1'b1;
        if (sts_i.reduce_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_MAX;
      end
      ST_MAX: begin
        cmd_o.reduce_max = 1'b1;
        if (sts_i.reduce_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/skp_datapath.sv -----
// Column height registers, window compare, shared min/max tournament and
// output register of the skyline strip packer. Depends on skp_pkg.
module skp_datapath import skp_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  skp_cmd_t                cmd_i,
  output skp_sts_t                sts_o,
  input  logic                    cfg_we_i,
  input  logic [StripWidthW-1:0]  cfg_wdata_i,
  input  logic [PieceWidthW-1:0]  piece_width_i,
  input  logic [PieceHeightW-1:0] piece_height_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    placed_o,
  output logic [CoordW-1:0]       x_left_o,
  output logic [OutHeightW-1:0]   y_bottom_o,
  output logic [CoordW-1:0]       x_right_o,
  output logic [OutHeightW-1:0]   y_top_o,
  output logic [OutHeightW-1:0]   strip_length_o,
  output logic                    height_overflow_o
);

  localparam int Lg   = $clog2(MAX_COLUMNS);
  localparam int Np   = 1 << Lg;
  localparam int CntW = ($clog2(MAX_COLUMNS + 1) > PieceWidthW) ?
                        $clog2(MAX_COLUMNS + 1) : PieceWidthW;
  localparam int AW   = CntW + 1;
  localparam int SumW = ((HEIGHT_BITS > OutHeightW) ? HEIGHT_BITS : OutHeightW) + 1;
  localparam logic [SumW-1:0] HeightMax =
    {{(SumW - HEIGHT_BITS){1'b0}}, {HEIGHT_BITS{1'b1}}};

  typedef struct packed {
    logic                   vld;
    logic [HEIGHT_BITS-1:0] hgt;
    logic [Lg-1:0]          idx;
  } cand_t;

  // Earlier operand always holds the lower column indices: it wins ties.
  function automatic cand_t pick(cand_t a, cand_t b, logic want_max);
    logic a_better;
    a_better = want_max ? (a.hgt >= b.hgt) : (a.hgt <= b.hgt);
    if (a.vld && (!b.vld || a_better)) begin
      return a;
    end
    return b;
  endfunction

  logic [StripWidthW-1:0]  sw_q;
  logic [HEIGHT_BITS-1:0]  h_q   [MAX_COLUMNS];
  logic [HEIGHT_BITS-1:0]  h_d   [MAX_COLUMNS];
  logic [HEIGHT_BITS-1:0]  win_q [MAX_COLUMNS];
  logic [HEIGHT_BITS-1:0]  win_d [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0]  ok_q, ok_d, ok_init;
  logic [PieceWidthW-1:0]  pw_q;
  logic [PieceHeightW-1:0] ph_q;
  logic [CntW-1:0]         cnt_q;
  cand_t                   cand_q [Np];
  cand_t                   cand_d [Np];

  logic                    res_placed_q, res_ovf_q;
  logic [CoordW-1:0]       res_xl_q, res_xr_q;
  logic [OutHeightW-1:0]   res_yb_q, res_yt_q;

  logic                    out_valid_q;
  logic                    placed_q, ovf_q;
  logic [CoordW-1:0]       xl_q, xr_q;
  logic [OutHeightW-1:0]   yb_q, yt_q, len_q;

  logic [CntW-1:0] sw_ext, cols, pw_in_ext, pw_ext, start_c, xr_c;
  logic [SumW-1:0] base_ext, sum, top, last, last_c, len_ext;
  logic            found;

  // Columns in use
  always_comb begin
    sw_ext    = CntW'(sw_q);
    cols      = (sw_ext > CntW'(MAX_COLUMNS)) ? CntW'(MAX_COLUMNS) : sw_ext;
    pw_in_ext = CntW'(piece_width_i);
    pw_ext    = CntW'(pw_q);
  end

  // Start flags at accept: the piece must fit inside the strip from there
  always_comb begin
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      ok_init[i] = (pw_in_ext != '0) && (piece_height_i != '0) &&
                   ((AW'(i) + AW'(pw_in_ext)) <= AW'(cols));
    end
  end

  // Window step: win holds h[i+k] at step k
  always_comb begin
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      ok_d[i] = ok_q[i] & (win_q[i] <= h_q[i]);
      if (i + 1 < MAX_COLUMNS) begin
        win_d[i] = win_q[i + 1];
      end else begin
        win_d[i] = '0;
      end
    end
  end

  // Commit arithmetic on the winning start
  always_comb begin
    found    = cand_q[0].vld;
    start_c  = CntW'(cand_q[0].idx);
    xr_c     = start_c + pw_ext - CntW'(1);
    base_ext = SumW'(cand_q[0].hgt);
    sum      = base_ext + SumW'(ph_q);
    top      = (sum > HeightMax) ? HeightMax : sum;
    last     = sum - SumW'(1);
    last_c   = (last > HeightMax) ? HeightMax : last;
    len_ext  = cand_q[0].vld ? SumW'(cand_q[0].hgt) : '0;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (cmd_i.commit && found && (AW'(c) >= AW'(start_c)) &&
          (AW'(c) < (AW'(start_c) + AW'(pw_ext)))) begin
        h_d[c] = top[HEIGHT_BITS-1:0];
      end else begin
        h_d[c] = h_q[c];
      end
    end
  end

  // Tournament: load or one level of reduction
  always_comb begin
    cand_d = cand_q;
    if (cmd_i.min_load) begin
      for (int i = 0; i < Np; i++) begin
        if (i < MAX_COLUMNS) begin
          cand_d[i] = '{vld: ok_d[i], hgt: h_q[i], idx: Lg'(i)};
        end else begin
          cand_d[i] = '0;
        end
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < Np; i++) begin
        if (i < MAX_COLUMNS) begin
          cand_d[i] = '{vld: (AW'(i) < AW'(cols)), hgt: h_d[i], idx: Lg'(i)};
        end else begin
          cand_d[i] = '0;
        end
      end
    end else if (cmd_i.reduce_min || cmd_i.reduce_max) begin
      for (int k = 0; k < Np / 2; k++) begin
        cand_d[k] = pick(cand_q[2 * k], cand_q[2 * k + 1], cmd_i.reduce_max);
      end
      for (int k = Np / 2; k < Np; k++) begin
        cand_d[k] = '0;
      end
    end
  end

  always_comb begin
    sts_o.scan_last   = (AW'(cnt_q) + AW'(1)) >= AW'(pw_ext);
    sts_o.reduce_last = (cnt_q == CntW'(Lg - 1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q        <= StripWidthReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        h_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        sw_q <= cfg_wdata_i;
      end
      h_q <= h_d;
      if (cmd_i.accept || cmd_i.min_load || cmd_i.commit) begin
        cnt_q <= '0;
      end else if (cmd_i.scan || cmd_i.reduce_min || cmd_i.reduce_max) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    if (cmd_i.accept) begin
      pw_q  <= piece_width_i;
      ph_q  <= piece_height_i;
      win_q <= h_q;
      ok_q  <= ok_init;
    end else if (cmd_i.scan) begin
      win_q <= win_d;
      ok_q  <= ok_d;
    end
    if (cmd_i.commit) begin
      res_placed_q <= found;
      res_ovf_q    <= found && (sum > HeightMax);
      res_xl_q     <= found ? start_c[CoordW-1:0] : '0;
      res_xr_q     <= found ? xr_c[CoordW-1:0] : '0;
      res_yb_q     <= found ? base_ext[OutHeightW-1:0] : '0;
      res_yt_q     <= found ? last_c[OutHeightW-1:0] : '0;
    end
    if (cmd_i.out_load) begin
      placed_q <= res_placed_q;
      ovf_q    <= res_ovf_q;
      xl_q     <= res_xl_q;
      xr_q     <= res_xr_q;
      yb_q     <= res_yb_q;
      yt_q     <= res_yt_q;
      len_q    <= len_ext[OutHeightW-1:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign placed_o          = placed_q;
  assign x_left_o          = xl_q;
  assign y_bottom_o        = yb_q;
  assign x_right_o         = xr_q;
  assign y_top_o           = yt_q;
  assign strip_length_o    = len_q;
  assign height_overflow_o = ovf_q;

endmodule

// ----- rtl/core/skyline_strip_packer_top.sv -----
// Skyline strip packer: bottom-left greedy placement of pieces in a strip.
// Requests are handled one at a time: a new one is taken only after the
// previous result has moved into the output register. The window scan
// steps one column offset per cycle, followed by the two tournament passes.
// Reset (async, active low) clears all column heights and sets strip width 64.
module skyline_strip_packer_top import skp_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration: strip width
  input  logic                    cfg_we_i,
  input  logic [StripWidthW-1:0]  cfg_wdata_i,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [PieceWidthW-1:0]  piece_width_i,
  input  logic [PieceHeightW-1:0] piece_height_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    placed_o,
  output logic [CoordW-1:0]       x_left_o,
  output logic [OutHeightW-1:0]   y_bottom_o,
  output logic [CoordW-1:0]       x_right_o,
  output logic [OutHeightW-1:0]   y_top_o,
  output logic [OutHeightW-1:0]   strip_length_o,
  output logic                    height_overflow_o
);

  // Flow per request:
  //   accept  : latch piece, copy heights into the shift window, flag starts
  //             where the piece fits in the strip
  //   scan    : for offsets k below pw, each start i compares h[i+k] against h[i]
  //   min     : clog2 levels of tournament, lowest base wins, ties to the left
  //   commit  : raise covered columns (saturating), load new heights for max
  //   max     : clog2 levels of tournament giving the strip length
  //   out     : result into output register; a new request is taken while
  //             the previous result still waits downstream
  skp_cmd_t cmd;
  skp_sts_t sts;

  skp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  skp_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .piece_width_i     (piece_width_i),
    .piece_height_i    (piece_height_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .placed_o          (placed_o),
    .x_left_o          (x_left_o),
    .y_bottom_o        (y_bottom_o),
    .x_right_o         (x_right_o),
    .y_top_o           (y_top_o),
    .strip_length_o    (strip_length_o),
    .height_overflow_o (height_overflow_o)
  );

endmodule

// ----- rtl/core/skp_checker.sv -----
// Port-level checks for the skyline strip packer, bound to the top level.
// Depends on skp_pkg and skyline_strip_packer_top.
module skp_checker import skp_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic                    placed_o,
  input logic [CoordW-1:0]       x_left_o,
  input logic [OutHeightW-1:0]   y_bottom_o,
  input logic [CoordW-1:0]       x_right_o,
  input logic [OutHeightW-1:0]   y_top_o,
  input logic [OutHeightW-1:0]   strip_length_o,
  input logic                    height_overflow_o
);

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(y_top_o) &&
    $stable(strip_length_o) && $stable(x_left_o))
    else $error("result changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in work");

  // unplaced piece reports zero corners and no overflow
  a_unplaced_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !placed_o |-> x_left_o == '0 && x_right_o == '0 &&
    y_bottom_o == '0 && y_top_o == '0 && !height_overflow_o)
    else $error("unplaced result carries corner data");

  // overflow only for placed pieces
  a_ovf_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && height_overflow_o |-> placed_o)
    else $error("overflow flagged on unplaced piece");

endmodule

bind skyline_strip_packer_top skp_checker u_skp_checker (.*);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for skyline_strip_packer_top: directed and random pieces.
// Each result is checked against a skyline predictor kept inside the bench.
// Depends on skp_pkg and the skyline_strip_packer_top RTL only.
module tb_top;
  import skp_pkg::*;

  localparam int MaxCols    = 64;
  localparam int CycleLimit = 1_000_000;
  localparam int MaxPrinted = 50;

  // One expected placement, field for field as on the result port
  typedef struct packed {
    logic                  placed;
    logic [CoordW-1:0]     x_left;
    logic [OutHeightW-1:0] y_bottom;
    logic [CoordW-1:0]     x_right;
    logic [OutHeightW-1:0] y_top;
    logic [OutHeightW-1:0] strip_length;
    logic                  height_overflow;
  } placement_t;

  // DUT ports; every input known from time zero
  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_we_i       = 1'b0;
  logic [StripWidthW-1:0]  cfg_wdata_i    = '0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic [PieceWidthW-1:0]  piece_width_i  = '0;
  logic [PieceHeightW-1:0] piece_height_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic                    placed_o;
  logic [CoordW-1:0]       x_left_o;
  logic [OutHeightW-1:0]   y_bottom_o;
  logic [CoordW-1:0]       x_right_o;
  logic [OutHeightW-1:0]   y_top_o;
  logic [OutHeightW-1:0]   strip_length_o;
  logic                    height_overflow_o;

  // Predictor state: skyline heights and the strip width register
  logic [OutHeightW-1:0]   col_height [MaxCols];
  logic [StripWidthW-1:0]  strip_cols;

  placement_t  placement_q [$];   // expected placements, oldest first
  int          err_count     = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0; // chance per cycle that no request is offered
  int unsigned recv_idle_pct = 0; // chance per cycle that results are refused
  int unsigned holdoff_left  = 0; // cycles of forced result back-pressure

  skyline_strip_packer_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .piece_width_i     (piece_width_i),
    .piece_height_i    (piece_height_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .placed_o          (placed_o),
    .x_left_o          (x_left_o),
    .y_bottom_o        (y_bottom_o),
    .x_right_o         (x_right_o),
    .y_top_o           (y_top_o),
    .strip_length_o    (strip_length_o),
    .height_overflow_o (height_overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop: well beyond the slowest legal run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d placements outstanding",
               cycle_count, placement_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Bottom-left skyline placement of one piece. Updates the predictor's
  // column heights and returns the result the block must report.
  function automatic placement_t place_piece(input logic [PieceWidthW-1:0] w,
                                             input logic [PieceHeightW-1:0] h);
    placement_t            r;
    int                    cols;
    int                    start;
    int                    i;
    int                    j;
    bit                    found;
    bit                    fits;
    logic [OutHeightW-1:0] base;
    logic [OutHeightW:0]   top;
    logic [OutHeightW:0]   last;
    r     = '0;
    found = 1'b0;
    start = 0;
    base  = '0;
    // register values above the array size use the whole array
    cols  = (strip_cols > MaxCols) ? MaxCols : int'(strip_cols);
    if (w != 0 && h != 0 && w <= cols) begin
      for (i = 0; i + w <= cols; i++) begin
        // start column must be the highest one under the piece
        fits = 1'b1;
        for (j = 0; j < w; j++)
          if (col_height[i + j] > col_height[i]) fits = 1'b0;
        // strict compare keeps the lowest index on a tie
        if (fits && (!found || col_height[i] < base)) begin
          found = 1'b1;
          start = i;
          base  = col_height[i];
        end
      end
    end
    if (found) begin
      top  = {1'b0, base} + {1'b0, h};
      last = top - 1;
      // saturate at the top of the height range
      if (top > {1'b0, {OutHeightW{1'b1}}}) begin
        top               = {1'b0, {OutHeightW{1'b1}}};
        r.height_overflow = 1'b1;
      end
      if (last > {1'b0, {OutHeightW{1'b1}}}) last = {1'b0, {OutHeightW{1'b1}}};
      for (j = 0; j < w; j++) col_height[start + j] = top[OutHeightW-1:0];
      r.placed   = 1'b1;
      r.x_left   = start[CoordW-1:0];
      r.y_bottom = base;
      r.x_right  = CoordW'(start + w - 1);
      r.y_top    = last[OutHeightW-1:0];
    end
    // running length over the columns currently in use only
    for (i = 0; i < cols; i++)
      if (col_height[i] > r.strip_length) r.strip_length = col_height[i];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < MaxPrinted)
      $display("mismatch @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Result side: random stalls, plus a long forced hold-off when requested
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      out_ready_i <= 1'b0;
      holdoff_left--;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Compare every accepted result with the oldest expected placement
  always @(posedge clk_i) begin : result_check
    placement_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (placement_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", 0, 0);
      end else begin
        want = placement_q.pop_front();
        if (placed_o !== want.placed)
          report_mismatch("placed", placed_o, want.placed);
        if (x_left_o !== want.x_left)
          report_mismatch("x_left", x_left_o, want.x_left);
        if (y_bottom_o !== want.y_bottom)
          report_mismatch("y_bottom", y_bottom_o, want.y_bottom);
        if (x_right_o !== want.x_right)
          report_mismatch("x_right", x_right_o, want.x_right);
        if (y_top_o !== want.y_top)
          report_mismatch("y_top", y_top_o, want.y_top);
        if (strip_length_o !== want.strip_length)
          report_mismatch("strip_length", strip_length_o, want.strip_length);
        if (height_overflow_o !== want.height_overflow)
          report_mismatch("height_overflow", height_overflow_o, want.height_overflow);
      end
    end
  end

  // Offer one piece request and hold it until the block takes it. Called at
  // a rising edge; valid is left high so back-to-back requests need no drop.
  task automatic send_piece(input logic [PieceWidthW-1:0] w,
                            input logic [PieceHeightW-1:0] h);
    int gaps;
    gaps = 0;
    while ($urandom_range(99, 0) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid_i <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    piece_width_i  <= w;
    piece_height_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    placement_q.insert(placement_q.size(), place_piece(w, h));
  endtask

  // Stop requesting and let every outstanding result come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk_i);
  endtask

  // Strip width may only change while the block is idle
  task automatic write_strip_width(input logic [StripWidthW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    strip_cols   = value;
  endtask

  // Field extremes at the reset width of 64 columns
  task automatic test_edge_pieces();
    send_piece(7'd1, 16'd1);
    send_piece(7'd64, 16'd1);       // whole strip
    send_piece(7'd0, 16'd5);        // zero width: not placed
    send_piece(7'd3, 16'd0);        // zero height: not placed
    send_piece(7'd65, 16'd1);       // one column too wide
    send_piece(7'd127, 16'hFFFF);   // all ones, far too wide
    send_piece(7'd63, 16'd2);
    send_piece(7'd64, 16'd3);
  endtask

  // Width register extremes and a skyline with no legal start
  task automatic test_strip_widths();
    write_strip_width(7'd0);        // no columns: nothing placed, length 0
    send_piece(7'd1, 16'd1);
    write_strip_width(7'd127);      // above array size: all 64 columns
    send_piece(7'd64, 16'd2);
    send_piece(7'd5, 16'd7);
    write_strip_width(7'd2);
    send_piece(7'd1, 16'd1);        // left column rises
    send_piece(7'd1, 16'd3);        // right column rises above it
    send_piece(7'd2, 16'd1);        // left start blocked, right start off the strip
    write_strip_width(7'd1);
    send_piece(7'd2, 16'd1);        // wider than the strip
    send_piece(7'd1, 16'd4);
    write_strip_width(7'd3);
    send_piece(7'd3, 16'd1);
  endtask

  // Random pieces, mostly narrow and short so the skyline stays interesting
  task automatic test_random_pieces(input logic [StripWidthW-1:0] width,
                                    input int unsigned send_pct,
                                    input int unsigned recv_pct,
                                    input int count);
    int unsigned             pick;
    logic [PieceWidthW-1:0]  w;
    logic [PieceHeightW-1:0] h;
    write_strip_width(width);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      if (pick < 70)      w = PieceWidthW'($urandom_range(16, 1));
      else if (pick < 90) w = PieceWidthW'($urandom_range(64, 1));
      else                w = PieceWidthW'($urandom_range(127, 0));
      pick = $urandom_range(99, 0);
      if (pick == 0)      h = PieceHeightW'($urandom_range(65535, 0));
      else if (pick < 3)  h = '0;
      else                h = PieceHeightW'($urandom_range(48, 1));
      send_piece(w, h);
    end
  endtask

  // Results refused for a long stretch while requests keep coming
  task automatic test_backpressure();
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holdoff_left  = 400;
    repeat (12) send_piece(PieceWidthW'($urandom_range(8, 1)),
                           PieceHeightW'($urandom_range(20, 1)));
  endtask

  // Column height clamps at the top of the range
  task automatic test_height_saturation();
    write_strip_width(7'd1);
    send_piece(7'd1, 16'hFFFF);     // column already above zero: clamps at the top
    send_piece(7'd1, 16'd1);        // one more on the clamped column
    send_piece(7'd1, 16'hFFFF);     // already at the top
    write_strip_width(7'd64);
    send_piece(7'd64, 16'd100);
  endtask

  initial begin
    for (int c = 0; c < MaxCols; c++) col_height[c] = '0;
    strip_cols    = StripWidthReset;
    send_idle_pct = 16;
    recv_idle_pct = 79;

    // single reset pulse
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_pieces();
    test_strip_widths();
    test_random_pieces(7'd64, 16, 79, 300);
    test_random_pieces(7'($urandom_range(56, 8)), 79, 16, 300);
    test_random_pieces(7'd127, 0, 0, 300);
    test_backpressure();
    test_height_saturation();

    // all requests sent: collect the rest, then allow for the pipeline depth
    drain_results();
    repeat (100) @(posedge clk_i);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
